@@ rtl/i2cra_pkg.sv @@
// i2c master register access: shared types, codes and constants
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package i2cra_pkg;

  localparam int WRITE_DEPTH = 256;
  localparam int WB_AW       = $clog2(WRITE_DEPTH);

  localparam logic [15:0] PHASE_TICKS_RESET = 16'd8;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    K_IDLE    = 3'd0,
    K_START   = 3'd1,
    K_RESTART = 3'd2,
    K_SEND    = 3'd3,
    K_WACK    = 3'd4,
    K_RECV    = 3'd5,
    K_MACK    = 3'd6,
    K_STOP    = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    R_ADDRW = 2'd0,
    R_REG   = 2'd1,
    R_DATA  = 2'd2,
    R_ADDRR = 2'd3
  } role_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BUSY      = 3'd1;
  localparam logic [2:0] ST_BUS_BUSY  = 3'd2;
  localparam logic [2:0] ST_ADDR_NACK = 3'd3;
  localparam logic [2:0] ST_DATA_NACK = 3'd4;

  typedef struct packed {
    logic [1:0] command;
    logic [6:0] device_address;
    logic [7:0] register_address;
    logic [7:0] byte_count;
    logic [7:0] byte_index;
    logic [7:0] write_data;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       last_byte;
    logic       done_res;
    logic [2:0] status;
  } rsp_t;

  typedef struct packed {
    logic             en;
    logic [WB_AW-1:0] addr;
    logic [7:0]       data;
  } wb_wr_t;

endpackage

`default_nettype wire

@@ rtl/i2cra_wbuf.sv @@
// write buffer memory with two registered read ports and write forwarding
// depends on i2cra_pkg
`timescale 1ns / 1ps
`default_nettype none

module i2cra_wbuf import i2cra_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire wb_wr_t           wb_wr,
  input  wire logic [WB_AW-1:0] rd_addr,
  output logic      [7:0]       cur_byte,
  output logic      [7:0]       nxt_byte
);

  logic [7:0]       mem [WRITE_DEPTH];
  logic [WB_AW-1:0] rd_addr1;
  logic [7:0]       rd0;
  logic [7:0]       rd1;
  logic [7:0]       fwd_data;
  logic             fwd0;
  logic             fwd1;

  assign rd_addr1 = WB_AW'(rd_addr + 1'b1);

  always_ff @(posedge clk) begin
    if (wb_wr.en) begin
      mem[wb_wr.addr] <= wb_wr.data;
    end
    rd0      <= mem[rd_addr];
    rd1      <= mem[rd_addr1];
    fwd_data <= wb_wr.data;
  end

  // a write to the slot being read this cycle wins over the stale read
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd0 <= 1'b0;
      fwd1 <= 1'b0;
    end else begin
      fwd0 <= wb_wr.en && (wb_wr.addr == rd_addr);
      fwd1 <= wb_wr.en && (wb_wr.addr == rd_addr1);
    end
  end

  assign cur_byte = fwd0 ? fwd_data : rd0;
  assign nxt_byte = fwd1 ? fwd_data : rd1;

endmodule

`default_nettype wire

@@ rtl/i2cra_seq.sv @@
// bus sequencer: phase timer, bit/byte control and line drive
// depends on i2cra_pkg; takes buffer bytes from i2cra_wbuf
`timescale 1ns / 1ps
`default_nettype none

module i2cra_seq import i2cra_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire req_t             req,
  input  wire logic [15:0]      phase_ticks,
  input  wire logic [7:0]       cur_byte,
  input  wire logic [7:0]       nxt_byte,
  output wb_wr_t                wb_wr,
  output logic      [WB_AW-1:0] rd_addr,
  output rsp_t                  rsp_next
);

  kind_t       kind, kind_next;
  logic [1:0]  sub, sub_next;
  logic [15:0] pc, pc_next;
  logic [3:0]  bc, bc_next;
  logic [7:0]  sh, sh_next;
  logic [7:0]  bl, bl_next;
  logic [7:0]  bp, bp_next;
  logic [6:0]  ta, ta_next;
  logic [7:0]  tr, tr_next;
  logic        reading, reading_next;
  role_t       role, role_next;
  logic [2:0]  ss, ss_next;
  logic        scl, scl_next;
  logic        sda, sda_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind    <= K_IDLE;
      sub     <= 2'd0;
      pc      <= '0;
      bc      <= '0;
      sh      <= '0;
      bl      <= '0;
      bp      <= '0;
      ta      <= '0;
      tr      <= '0;
      reading <= 1'b0;
      role    <= R_ADDRW;
      ss      <= ST_OK;
      scl     <= 1'b1;
      sda     <= 1'b1;
    end else begin
      kind    <= kind_next;
      sub     <= sub_next;
      pc      <= pc_next;
      bc      <= bc_next;
      sh      <= sh_next;
      bl      <= bl_next;
      bp      <= bp_next;
      ta      <= ta_next;
      tr      <= tr_next;
      reading <= reading_next;
      role    <= role_next;
      ss      <= ss_next;
      scl     <= scl_next;
      sda     <= sda_next;
    end
  end

  assign wb_wr.en   = accept && (cmd_t'(req.command) == CMD_LOAD) &&
                      ({1'b0, req.byte_index} < 9'(WRITE_DEPTH));
  assign wb_wr.addr = req.byte_index[WB_AW-1:0];
  assign wb_wr.data = req.write_data;
  assign rd_addr    = bp_next[WB_AW-1:0];

  always_comb begin
    logic        go;
    logic [15:0] pc_inc;
    logic [15:0] limit;
    logic [3:0]  bc_inc;
    logic [7:0]  bl_dec;
    logic [7:0]  shv;
    logic        sda_bit;
    logic [7:0]  o_byte;
    logic        o_valid;
    logic        o_last;
    logic        o_done;
    logic [2:0]  o_stat;

    kind_next    = kind;
    sub_next     = sub;
    pc_next      = pc;
    bc_next      = bc;
    sh_next      = sh;
    bl_next      = bl;
    bp_next      = bp;
    ta_next      = ta;
    tr_next      = tr;
    reading_next = reading;
    role_next    = role;
    ss_next      = ss;
    scl_next     = scl;
    sda_next     = sda;
    go           = 1'b0;
    o_byte       = '0;
    o_valid      = 1'b0;
    o_last       = 1'b0;
    o_done       = 1'b0;
    o_stat       = ST_OK;
    pc_inc       = pc + 16'd1;
    limit        = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
    bc_inc       = bc + 4'd1;
    bl_dec       = bl - 8'd1;
    shv          = {sh[6:0], req.sda_in};
    sda_bit      = req.sda_in;

    if (accept) begin
      unique case (cmd_t'(req.command))
        CMD_LOAD: begin
        end
        CMD_WRITE, CMD_READ: begin
          if (kind == K_IDLE) begin
            reading_next = (cmd_t'(req.command) == CMD_READ);
            ta_next      = req.device_address;
            tr_next      = req.register_address;
            bl_next      = req.byte_count;
            bp_next      = '0;
            ss_next      = ST_OK;
            kind_next    = K_START;
            sub_next     = 2'd0;
            go           = 1'b1;
          end
        end
        default: begin
          if (kind != K_IDLE) begin
            pc_next = pc_inc;
            if (pc_inc >= limit || pc_inc == 16'd0) begin
              go = 1'b1;
              unique case (kind)
                K_START: begin
                  if (sub == 2'd0) begin
                    if (!sda_bit) begin
                      kind_next = K_IDLE; sub_next = 2'd0;
                      o_done = 1'b1; o_stat = ST_BUS_BUSY;
                    end else begin
                      sub_next = 2'd1;
                    end
                  end else if (sub == 2'd1) begin
                    if (sda_bit) begin
                      kind_next = K_IDLE; sub_next = 2'd0;
                      o_done = 1'b1; o_stat = ST_BUS_BUSY;
                    end else begin
                      sub_next = 2'd2;
                    end
                  end else begin
                    sh_next = {ta, 1'b0}; role_next = R_ADDRW; bc_next = '0;
                    kind_next = K_SEND; sub_next = 2'd0;
                  end
                end
                K_RESTART: begin
                  if (sub < 2'd2) begin
                    sub_next = sub + 2'd1;
                  end else begin
                    sh_next = {ta, 1'b1}; role_next = R_ADDRR; bc_next = '0;
                    kind_next = K_SEND; sub_next = 2'd0;
                  end
                end
                K_SEND: begin
                  if (sub < 2'd2) begin
                    sub_next = sub + 2'd1;
                  end else begin
                    sh_next   = {sh[6:0], 1'b0};
                    bc_next   = bc_inc;
                    kind_next = bc_inc[3] ? K_WACK : K_SEND;
                    sub_next  = 2'd0;
                  end
                end
                K_WACK: begin
                  if (sub < 2'd2) begin
                    sub_next = sub + 2'd1;
                  end else begin
                    sub_next = 2'd0;
                    case (role)
                      R_ADDRW: begin
                        if (sda_bit) begin
                          ss_next = ST_ADDR_NACK; kind_next = K_STOP;
                        end else begin
                          sh_next = tr; role_next = R_REG; bc_next = '0;
                          kind_next = K_SEND;
                        end
                      end
                      R_REG: begin
                        if (reading) begin
                          kind_next = K_RESTART;
                        end else if (bl == 8'd0) begin
                          ss_next = ST_OK; kind_next = K_STOP;
                        end else begin
                          sh_next = cur_byte; role_next = R_DATA; bc_next = '0;
                          kind_next = K_SEND;
                        end
                      end
                      R_DATA: begin
                        if (sda_bit) begin
                          ss_next = ST_DATA_NACK; kind_next = K_STOP;
                        end else begin
                          bl_next = bl_dec;
                          bp_next = bp + 8'd1;
                          if (bl_dec == 8'd0) begin
                            ss_next = ST_OK; kind_next = K_STOP;
                          end else begin
                            sh_next = nxt_byte; role_next = R_DATA; bc_next = '0;
                            kind_next = K_SEND;
                          end
                        end
                      end
                      default: begin
                        if (bl == 8'd0) begin
                          ss_next = ST_OK; kind_next = K_STOP;
                        end else begin
                          sh_next = '0; bc_next = '0; kind_next = K_RECV;
                        end
                      end
                    endcase
                  end
                end
                K_RECV: begin
                  if (sub == 2'd0) begin
                    sub_next = 2'd1;
                  end else begin
                    sh_next  = shv;
                    bc_next  = bc_inc;
                    sub_next = 2'd0;
                    if (bc_inc[3]) begin
                      o_byte    = shv;
                      o_valid   = 1'b1;
                      o_last    = (bl == 8'd1);
                      kind_next = K_MACK;
                    end else begin
                      kind_next = K_RECV;
                    end
                  end
                end
                K_MACK: begin
                  if (sub < 2'd3) begin
                    sub_next = sub + 2'd1;
                  end else begin
                    bl_next  = bl_dec;
                    sub_next = 2'd0;
                    if (bl_dec == 8'd0) begin
                      ss_next = ST_OK; kind_next = K_STOP;
                    end else begin
                      sh_next = '0; bc_next = '0; kind_next = K_RECV;
                    end
                  end
                end
                K_STOP: begin
                  if (sub < 2'd3) begin
                    sub_next = sub + 2'd1;
                  end else begin
                    kind_next = K_IDLE; sub_next = 2'd0;
                    o_done = 1'b1; o_stat = ss;
                  end
                end
                default: begin
                  go = 1'b0;
                end
              endcase
            end
          end
        end
      endcase
    end

    // line drive on entry to the next phase
    if (go) begin
      pc_next = '0;
      unique case (kind_next)
        K_START, K_RESTART: begin
          scl_next = 1'b1;
          sda_next = (sub_next == 2'd0);
        end
        K_SEND: begin
          scl_next = (sub_next == 2'd2);
          sda_next = (sub_next != 2'd0) ? sh_next[7] : sda;
        end
        K_WACK: begin
          scl_next = (sub_next == 2'd2);
          sda_next = (sub_next != 2'd0) ? 1'b1 : sda;
        end
        K_RECV: begin
          scl_next = (sub_next == 2'd1);
          sda_next = 1'b1;
        end
        K_MACK: begin
          scl_next = (sub_next == 2'd2);
          sda_next = (sub_next == 2'd0) ? 1'b1 : (bl_next == 8'd1);
        end
        K_STOP: begin
          scl_next = sub_next[1];
          if (sub_next == 2'd1 || sub_next == 2'd2) begin
            sda_next = 1'b0;
          end else if (sub_next == 2'd3) begin
            sda_next = 1'b1;
          end else begin
            sda_next = sda;
          end
        end
        default: begin
          scl_next = 1'b1;
          sda_next = 1'b1;
        end
      endcase
    end

    if (!o_done) begin
      o_stat = (kind_next == K_IDLE) ? ST_OK : ST_BUSY;
    end

    rsp_next.scl_out    = scl_next;
    rsp_next.sda_out    = sda_next;
    rsp_next.read_byte  = o_byte;
    rsp_next.read_valid = o_valid;
    rsp_next.last_byte  = o_last;
    rsp_next.done_res   = o_done;
    rsp_next.status     = o_stat;
  end

endmodule

`default_nettype wire

@@ rtl/i2c_master_register_access_unit.sv @@
// response: a request's response is registered on acceptance
// throughput: one request per clock; two-entry output stage takes a new request
//   while a response waits, req_stall rises only when both entries are full
// reset: sequencer idle, both lines released, phase_ticks back to 8; write buffer
//   contents are undefined until loaded, so no clearing pass is run
// top level: i2cra_seq, i2cra_wbuf, i2cra_pkg
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_register_access_unit import i2cra_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire req_t        req,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output rsp_t             rsp,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  logic             accept;
  logic             pop;
  logic [15:0]      phase_ticks;
  wb_wr_t           wb_wr;
  logic [WB_AW-1:0] rd_addr;
  logic [7:0]       cur_byte;
  logic [7:0]       nxt_byte;
  rsp_t             rsp_next;
  rsp_t             out_data;
  rsp_t             skid_data;
  logic             out_valid;
  logic             skid_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      phase_ticks <= cfg_data;
    end
  end

  assign accept    = req_valid && !req_stall;
  assign req_stall = skid_valid;
  assign pop       = out_valid && !rsp_stall;

  i2cra_wbuf u_wbuf (
    .clk      (clk),
    .rst      (rst),
    .wb_wr    (wb_wr),
    .rd_addr  (rd_addr),
    .cur_byte (cur_byte),
    .nxt_byte (nxt_byte)
  );

  i2cra_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .req         (req),
    .phase_ticks (phase_ticks),
    .cur_byte    (cur_byte),
    .nxt_byte    (nxt_byte),
    .wb_wr       (wb_wr),
    .rd_addr     (rd_addr),
    .rsp_next    (rsp_next)
  );

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (accept) begin
      if (out_valid && !pop) begin
        skid_data <= rsp_next;
      end else begin
        out_data <= rsp_next;
      end
    end
  end

  assign rsp_valid = out_valid;
  assign rsp       = out_data;

endmodule

`default_nettype wire

@@ rtl/i2cra_chk.sv @@
// port-level checks on the response channel of the register access unit
// depends on i2cra_pkg; bound to i2c_master_register_access_unit
`timescale 1ns / 1ps
`default_nettype none

module i2cra_chk import i2cra_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic rsp_valid,
  input wire logic rsp_stall,
  input wire rsp_t rsp
);

  // stalled response holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // received bytes only appear mid transaction
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.read_valid |-> rsp.status == ST_BUSY && !rsp.done_res)
    else $error("read byte outside a running transaction");

  // no stale read data
  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.read_valid |-> rsp.read_byte == 8'd0 && !rsp.last_byte)
    else $error("read byte without read_valid");

  // finish carries a final status
  a_done_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.done_res |->
      rsp.status == ST_OK || rsp.status == ST_BUS_BUSY ||
      rsp.status == ST_ADDR_NACK || rsp.status == ST_DATA_NACK)
    else $error("bad status on done");

  // idle bus has both lines released
  a_idle_lines: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_OK |-> rsp.scl_out && rsp.sda_out)
    else $error("lines driven while idle");

endmodule

bind i2c_master_register_access_unit i2cra_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire

@@ bench/tb_top.sv @@
// tb_top: self-checking bench for i2c_master_register_access_unit
// sends requests with random gaps and stalls, predicts each response in-line and checks it
// depends on i2cra_pkg and the rtl top level only
`timescale 1ns / 1ps

module tb_top;
  import i2cra_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  i2c_master_register_access_unit dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sequencer copy
  kind_t       seq_kind;
  logic [1:0]  seq_sub;
  logic [15:0] tick_cnt;
  logic [3:0]  bits_done;
  logic [7:0]  shreg;
  logic [7:0]  bytes_left;
  logic [7:0]  buf_ptr;
  logic [6:0]  dev_addr;
  logic [7:0]  reg_addr;
  logic        reading;
  logic [7:0]  wbuf [WRITE_DEPTH];
  logic        scl_drv;
  logic        sda_drv;
  role_t       cur_role;
  logic [2:0]  pending_status;
  logic [15:0] tick_limit;
  rsp_t        step_rsp;

  rsp_t        due_rsp_q[$];
  rsp_t        want;
  bit          slot_loaded [WRITE_DEPTH];
  int          errors = 0;
  int          sent_items = 0;
  int          cycle_count = 0;
  int          rsp_hold = 0;
  bit          pace_on = 1'b1;

  // bus responder knobs, in percent
  int bus_held_pct = 0;
  int start_lost_pct = 0;
  int nack_addr_pct = 0;
  int nack_data_pct = 0;
  int noise_pct = 0;

  function automatic void clear_sequencer();
    tick_limit = PHASE_TICKS_RESET;
    tick_cnt = '0;
    bits_done = '0;
    shreg = '0;
    bytes_left = '0;
    buf_ptr = '0;
    dev_addr = '0;
    reg_addr = '0;
    reading = 1'b0;
    cur_role = R_ADDRW;
    pending_status = ST_OK;
    seq_kind = K_IDLE;
    seq_sub = '0;
    scl_drv = 1'b1;
    sda_drv = 1'b1;
  endfunction

  function automatic void enter_phase(input kind_t k, input logic [1:0] s);
    logic scl, sda;
    scl = 1'b0;
    sda = sda_drv;
    case (k)
      K_START, K_RESTART: begin
        scl = 1'b1;
        sda = (s == 2'd0);
      end
      K_SEND: begin
        scl = (s == 2'd2);
        if (s != 2'd0) sda = shreg[7];
      end
      K_WACK: begin
        scl = (s == 2'd2);
        if (s != 2'd0) sda = 1'b1;
      end
      K_RECV: begin
        scl = (s == 2'd1);
        sda = 1'b1;
      end
      K_MACK: begin
        scl = (s == 2'd2);
        sda = (s == 2'd0) || (bytes_left == 8'd1);
      end
      K_STOP: begin
        scl = (s >= 2'd2);
        if (s == 2'd1 || s == 2'd2) sda = 1'b0;
        else if (s == 2'd3) sda = 1'b1;
      end
      default: begin
        scl = 1'b1;
        sda = 1'b1;
      end
    endcase
    seq_kind = k;
    seq_sub = s;
    tick_cnt = '0;
    scl_drv = scl;
    sda_drv = sda;
  endfunction

  function automatic void end_xfer(input logic [2:0] st);
    enter_phase(K_IDLE, 2'd0);
    step_rsp.done_res = 1'b1;
    step_rsp.status = st;
  endfunction

  function automatic void go_stop(input logic [2:0] st);
    pending_status = st;
    enter_phase(K_STOP, 2'd0);
  endfunction

  function automatic void shift_out(input logic [7:0] b, input role_t role);
    shreg = b;
    cur_role = role;
    bits_done = '0;
    enter_phase(K_SEND, 2'd0);
  endfunction

  function automatic void start_recv();
    shreg = '0;
    bits_done = '0;
    enter_phase(K_RECV, 2'd0);
  endfunction

  function automatic void ack_seen(input logic acked);
    case (cur_role)
      R_ADDRW: begin
        if (!acked) go_stop(ST_ADDR_NACK);
        else shift_out(reg_addr, R_REG);
      end
      R_REG: begin
        if (reading) enter_phase(K_RESTART, 2'd0);
        else if (bytes_left == 8'd0) go_stop(ST_OK);
        else shift_out(wbuf[buf_ptr], R_DATA);
      end
      R_DATA: begin
        if (!acked) begin
          go_stop(ST_DATA_NACK);
        end else begin
          bytes_left = bytes_left - 8'd1;
          buf_ptr = buf_ptr + 8'd1;
          if (bytes_left == 8'd0) go_stop(ST_OK);
          else shift_out(wbuf[buf_ptr], R_DATA);
        end
      end
      default: begin
        if (bytes_left == 8'd0) go_stop(ST_OK);
        else start_recv();
      end
    endcase
  endfunction

  function automatic void phase_end(input logic sda);
    case (seq_kind)
      K_START: begin
        if (seq_sub == 2'd0) begin
          if (!sda) end_xfer(ST_BUS_BUSY);
          else enter_phase(K_START, 2'd1);
        end else if (seq_sub == 2'd1) begin
          if (sda) end_xfer(ST_BUS_BUSY);
          else enter_phase(K_START, 2'd2);
        end else begin
          shift_out({dev_addr, 1'b0}, R_ADDRW);
        end
      end
      K_RESTART: begin
        if (seq_sub < 2'd2) enter_phase(K_RESTART, seq_sub + 2'd1);
        else shift_out({dev_addr, 1'b1}, R_ADDRR);
      end
      K_SEND: begin
        if (seq_sub < 2'd2) begin
          enter_phase(K_SEND, seq_sub + 2'd1);
        end else begin
          shreg = shreg << 1;
          bits_done = bits_done + 4'd1;
          if (bits_done >= 4'd8) enter_phase(K_WACK, 2'd0);
          else enter_phase(K_SEND, 2'd0);
        end
      end
      K_WACK: begin
        if (seq_sub < 2'd2) enter_phase(K_WACK, seq_sub + 2'd1);
        else ack_seen(!sda);
      end
      K_RECV: begin
        if (seq_sub == 2'd0) begin
          enter_phase(K_RECV, 2'd1);
        end else begin
          shreg = {shreg[6:0], sda};
          bits_done = bits_done + 4'd1;
          if (bits_done >= 4'd8) begin
            step_rsp.read_byte = shreg;
            step_rsp.read_valid = 1'b1;
            step_rsp.last_byte = (bytes_left == 8'd1);
            enter_phase(K_MACK, 2'd0);
          end else begin
            enter_phase(K_RECV, 2'd0);
          end
        end
      end
      K_MACK: begin
        if (seq_sub < 2'd3) begin
          enter_phase(K_MACK, seq_sub + 2'd1);
        end else begin
          bytes_left = bytes_left - 8'd1;
          if (bytes_left == 8'd0) go_stop(ST_OK);
          else start_recv();
        end
      end
      K_STOP: begin
        if (seq_sub < 2'd3) enter_phase(K_STOP, seq_sub + 2'd1);
        else end_xfer(pending_status);
      end
      default: ;
    endcase
  endfunction

  function automatic rsp_t sequencer_step(input req_t r);
    logic        was_idle;
    logic [15:0] lim;
    step_rsp = '0;
    was_idle = (seq_kind == K_IDLE);
    if (r.command == CMD_LOAD) begin
      wbuf[r.byte_index] = r.write_data;
    end else if (r.command == CMD_WRITE || r.command == CMD_READ) begin
      if (was_idle) begin
        reading = (r.command == CMD_READ);
        dev_addr = r.device_address;
        reg_addr = r.register_address;
        bytes_left = r.byte_count;
        buf_ptr = '0;
        pending_status = ST_OK;
        enter_phase(K_START, 2'd0);
      end
    end else if (!was_idle) begin
      lim = (tick_limit == 16'd0) ? 16'd1 : tick_limit;
      tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt >= lim || tick_cnt == 16'd0) phase_end(r.sda_in);
    end
    if (!step_rsp.done_res) step_rsp.status = (seq_kind == K_IDLE) ? ST_OK : ST_BUSY;
    step_rsp.scl_out = scl_drv;
    step_rsp.sda_out = sda_drv;
    return step_rsp;
  endfunction

  function automatic bit chance(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // what a target on the bus would show on the next sampled phase
  function automatic logic bus_sda();
    logic b;
    b = 1'($urandom_range(0, 1));
    case (seq_kind)
      K_START: begin
        if (seq_sub == 2'd0) b = !chance(bus_held_pct);
        else if (seq_sub == 2'd1) b = chance(start_lost_pct);
      end
      K_WACK: begin
        if (seq_sub == 2'd2 && cur_role == R_ADDRW) b = chance(nack_addr_pct);
        else if (seq_sub == 2'd2 && cur_role == R_DATA) b = chance(nack_data_pct);
      end
      default: ;
    endcase
    return b;
  endfunction

  function automatic req_t rand_req(input cmd_t c);
    logic [63:0] raw;
    req_t r;
    raw = {$urandom, $urandom};
    r = raw[$bits(req_t)-1:0];
    r.command = c;
    return r;
  endfunction

  function automatic req_t tick_req();
    req_t r;
    r = rand_req(CMD_TICK);
    r.sda_in = bus_sda();
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] e,
                                      input logic [7:0] a);
    if (a !== e) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
    end
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: timeout", $time);
      $display("Regression FAIL");
      $finish;
    end
  end

  // response checker and receiver pacing
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (due_rsp_q.size() == 0) begin
        errors++;
        $display("%0t ns: response with none expected, actual %p", $time, rsp);
      end else begin
        want = due_rsp_q.pop_front();
        check_field("scl_out", 8'(want.scl_out), 8'(rsp.scl_out));
        check_field("sda_out", 8'(want.sda_out), 8'(rsp.sda_out));
        check_field("read_byte", want.read_byte, rsp.read_byte);
        check_field("read_valid", 8'(want.read_valid), 8'(rsp.read_valid));
        check_field("last_byte", 8'(want.last_byte), 8'(rsp.last_byte));
        check_field("done_res", 8'(want.done_res), 8'(rsp.done_res));
        check_field("status", 8'(want.status), 8'(rsp.status));
      end
      rsp_hold = pace_on ? $urandom_range(0, 11) : 0;
    end
  end

  always @(negedge clk) begin
    if (rsp_hold > 0) begin
      rsp_stall <= 1'b1;
      rsp_hold--;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  task automatic send_req(input req_t r);
    int gap;
    gap = pace_on ? $urandom_range(0, 11) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    forever begin
      @(posedge clk);
      if (!req_stall) break;
    end
    due_rsp_q.push_back(sequencer_step(r));
    if (r.command == CMD_LOAD) slot_loaded[r.byte_index] = 1'b1;
    sent_items++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (due_rsp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_phase_ticks(input logic [15:0] v);
    drain_results();
    @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    tick_limit = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic fill_slots(input int count);
    req_t r;
    for (int i = 0; i < count; i++) begin
      if (!slot_loaded[i]) begin
        r = rand_req(CMD_LOAD);
        r.byte_index = i[7:0];
        send_req(r);
      end
    end
  endtask

  task automatic finish_xfer();
    req_t r;
    while (seq_kind != K_IDLE) begin
      if (chance(noise_pct)) begin
        // loads and starts while the bus is busy
        r = rand_req(chance(50) ? CMD_LOAD : cmd_t'($urandom_range(2, 3)));
        send_req(r);
      end else begin
        send_req(tick_req());
      end
    end
  endtask

  task automatic run_xfer(input cmd_t c, input logic [6:0] dev, input logic [7:0] regi,
                          input logic [7:0] cnt);
    req_t r;
    if (c == CMD_WRITE) fill_slots(cnt);
    r = rand_req(c);
    r.device_address = dev;
    r.register_address = regi;
    r.byte_count = cnt;
    send_req(r);
    finish_xfer();
  endtask

  task automatic quiet_bus();
    bus_held_pct = 0;
    start_lost_pct = 0;
    nack_addr_pct = 0;
    nack_data_pct = 0;
    noise_pct = 0;
  endtask

  task automatic test_idle_and_load();
    req_t r;
    r = rand_req(CMD_TICK);
    r.sda_in = 1'b0;
    send_req(r);
    r.sda_in = 1'b1;
    send_req(r);
    r = rand_req(CMD_LOAD);
    r.byte_index = 8'h00;
    r.write_data = 8'h00;
    send_req(r);
    r.byte_index = 8'hff;
    r.write_data = 8'hff;
    send_req(r);
    r.byte_index = 8'h01;
    r.write_data = 8'ha5;
    send_req(r);
  endtask

  task automatic test_default_write();
    bus_held_pct = 100;
    run_xfer(CMD_WRITE, 7'h7f, 8'hff, 8'd2);
    quiet_bus();
  endtask

  task automatic test_read();
    set_phase_ticks(16'd1);
    run_xfer(CMD_READ, 7'h00, 8'h00, 8'd3);
    run_xfer(CMD_READ, 7'h55, 8'haa, 8'd1);
  endtask

  task automatic test_zero_count();
    run_xfer(CMD_WRITE, 7'h2a, 8'h10, 8'd0);
    run_xfer(CMD_READ, 7'h15, 8'h01, 8'd0);
  endtask

  task automatic test_bus_not_free();
    bus_held_pct = 100;
    run_xfer(CMD_WRITE, 7'h11, 8'h22, 8'd1);
    bus_held_pct = 0;
    start_lost_pct = 100;
    run_xfer(CMD_READ, 7'h33, 8'h44, 8'd1);
    quiet_bus();
  endtask

  task automatic test_addr_nack();
    nack_addr_pct = 100;
    run_xfer(CMD_WRITE, 7'h50, 8'h01, 8'd2);
    run_xfer(CMD_READ, 7'h51, 8'h02, 8'd2);
    quiet_bus();
  endtask

  task automatic test_data_nack();
    nack_data_pct = 100;
    run_xfer(CMD_WRITE, 7'h3c, 8'h80, 8'd3);
    quiet_bus();
  endtask

  task automatic test_busy_commands();
    noise_pct = 30;
    run_xfer(CMD_WRITE, 7'h68, 8'h75, 8'd2);
    run_xfer(CMD_READ, 7'h68, 8'h3b, 8'd1);
    quiet_bus();
  endtask

  task automatic test_phase_extremes();
    req_t r;
    set_phase_ticks(16'd0);
    run_xfer(CMD_READ, 7'h0f, 8'hf0, 8'd1);
    set_phase_ticks(16'hffff);
    bus_held_pct = 100;
    r = rand_req(CMD_WRITE);
    r.device_address = 7'h70;
    r.register_address = 8'h07;
    r.byte_count = 8'd0;
    send_req(r);
    repeat (24) send_req(tick_req());
    set_phase_ticks(16'd1);
    finish_xfer();
    quiet_bus();
    set_phase_ticks(16'd2);
    run_xfer(CMD_WRITE, 7'h01, 8'hfe, 8'd0);
  endtask

  task automatic test_multi_byte();
    set_phase_ticks(16'd1);
    run_xfer(CMD_WRITE, 7'h24, 8'h5a, 8'd4);
    run_xfer(CMD_READ, 7'h5b, 8'ha4, 8'd4);
  endtask

  task automatic test_random_traffic();
    int stop_at;
    logic [7:0] cnt;
    stop_at = sent_items + 250;
    while (sent_items < stop_at) begin
      pace_on = ($urandom_range(0, 3) != 0);
      if (chance(15))
        set_phase_ticks(16'(chance(80) ? $urandom_range(1, 2) : $urandom_range(3, 6)));
      if (chance(10)) drain_results();
      if (chance(20)) begin
        repeat ($urandom_range(1, 4)) send_req(chance(50) ? tick_req() : rand_req(CMD_LOAD));
      end
      bus_held_pct = 5;
      start_lost_pct = 5;
      nack_addr_pct = 10;
      nack_data_pct = 5;
      noise_pct = 3;
      cnt = 8'(chance(85) ? $urandom_range(0, 3) : $urandom_range(4, 16));
      run_xfer(chance(50) ? CMD_WRITE : CMD_READ, 7'($urandom_range(0, 127)),
               8'($urandom_range(0, 255)), cnt);
    end
    quiet_bus();
    pace_on = 1'b1;
  endtask

  initial begin
    clear_sequencer();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_idle_and_load();
    test_default_write();
    test_read();
    test_zero_count();
    test_bus_not_free();
    test_addr_nack();
    test_data_nack();
    test_busy_commands();
    test_phase_extremes();
    test_multi_byte();
    test_random_traffic();
    drain_results();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
